// ----- rtl/core/cfa_instruction_encoder_core_defines.svh -----
// Assertion macros for the call-frame instruction encoder.
// IMPL checks the consequent in the same cycle, NEXT in the cycle after.
`ifndef CFA_INSTRUCTION_ENCODER_CORE_DEFINES_SVH
`define CFA_INSTRUCTION_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTH
`define CFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfa encoder: assertion failed");
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfa encoder: assertion failed");
`else
`define CFA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/cfa_enc_pkg.sv -----
package cfa_enc_pkg;

    localparam int CODE_W = 11;
    localparam int REG_W  = 5;
    localparam int OFF_W  = 32;
    localparam int OP_W   = 2;
    localparam int ERR_W  = 3;
    localparam int BYTE_W = 8;
    localparam int UPC_W  = 4;

    localparam int MAX_CODE_SIZE_DEF = 2047;

    // action codes
    localparam logic [OP_W-1:0] OP_DEF_CFA = 2'd0;
    localparam logic [OP_W-1:0] OP_SAVE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;
    localparam logic [OP_W-1:0] OP_FINISH  = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_CFA  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_REG  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_SAVE = 3'd4;
    localparam logic [ERR_W-1:0] ERR_FAILED   = 3'd5;

    localparam logic [REG_W-1:0]  REG_MAX     = 5'd16;
    localparam logic [5:0]        ADV_MAX     = 6'h3f;
    localparam logic [BYTE_W-1:0] BYTE_ADV    = 8'h40;
    localparam logic [BYTE_W-1:0] BYTE_SAVE   = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_REST   = 8'hc0;
    localparam logic [BYTE_W-1:0] BYTE_DEFCFA = 8'h0c;
    localparam logic [BYTE_W-1:0] BYTE_CONT   = 8'h80;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ERR,
        EM_ADV,
        EM_CFA,
        EM_ULEB,
        EM_SAVE,
        EM_REST,
        EM_PAD
    } emit_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_REG,
        LD_RAW,
        LD_SAVE
    } load_t;

    typedef enum logic [2:0] {
        BR_SEQ,
        BR_DISPATCH,
        BR_LOOP,
        BR_LOOP_OP,
        BR_LOOP_DONE,
        BR_DONE
    } branch_t;

    typedef struct packed {
        emit_t   emit;
        load_t   ld;
        branch_t br;
        upc_t    tgt;
    } uword_t;

    // sequencer -> datapath
    typedef struct packed {
        emit_t emit;
        load_t ld;
        logic  step;
        logic  leave;
        logic  disp;
        logic  last;
        logic  done;
    } seq_ctl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic slot_free;
        logic loop_more;
        logic disp_done;
        upc_t disp_upc;
        upc_t op_upc;
    } dp_stat_t;

    // microprogram entry points
    localparam upc_t UA_DISPATCH = 4'd0;
    localparam upc_t UA_ERR      = 4'd1;
    localparam upc_t UA_ADV      = 4'd2;
    localparam upc_t UA_CFA      = 4'd3;
    localparam upc_t UA_CFA_REG  = 4'd4;
    localparam upc_t UA_CFA_OFF  = 4'd5;
    localparam upc_t UA_SAVE     = 4'd6;
    localparam upc_t UA_SAVE_OFF = 4'd7;
    localparam upc_t UA_REST     = 4'd8;
    localparam upc_t UA_PAD      = 4'd9;

    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        case (addr)
            UA_DISPATCH: w = '{EM_NONE, LD_NONE, BR_DISPATCH,  UA_DISPATCH};
            UA_ERR:      w = '{EM_ERR,  LD_NONE, BR_DONE,      UA_DISPATCH};
            UA_ADV:      w = '{EM_ADV,  LD_NONE, BR_LOOP_OP,   UA_DISPATCH};
            UA_CFA:      w = '{EM_CFA,  LD_REG,  BR_SEQ,       UA_CFA_REG};
            UA_CFA_REG:  w = '{EM_ULEB, LD_RAW,  BR_LOOP,      UA_CFA_OFF};
            UA_CFA_OFF:  w = '{EM_ULEB, LD_NONE, BR_LOOP_DONE, UA_DISPATCH};
            UA_SAVE:     w = '{EM_SAVE, LD_SAVE, BR_SEQ,       UA_SAVE_OFF};
            UA_SAVE_OFF: w = '{EM_ULEB, LD_NONE, BR_LOOP_DONE, UA_DISPATCH};
            UA_REST:     w = '{EM_REST, LD_NONE, BR_DONE,      UA_DISPATCH};
            UA_PAD:      w = '{EM_PAD,  LD_NONE, BR_LOOP_DONE, UA_DISPATCH};
            default:     w = '{EM_NONE, LD_NONE, BR_DONE,      UA_DISPATCH};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/cfa_enc_useq.sv -----
`include "cfa_instruction_encoder_core_defines.svh"

module cfa_enc_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cfa_enc_pkg::dp_stat_t stat,
    output cfa_enc_pkg::seq_ctl_t ctl,
    output logic                 busy
);
    import cfa_enc_pkg::*;

    logic   busy_reg, busy_next;
    upc_t   upc_reg, upc_next;
    uword_t uw;
    logic   step;
    logic   stay;
    logic   done;
    upc_t   upc_step;

    assign uw   = ucode_rom(upc_reg);
    assign step = busy_reg && (uw.emit == EM_NONE || stat.slot_free);
    assign stay = (uw.br == BR_LOOP || uw.br == BR_LOOP_OP || uw.br == BR_LOOP_DONE)
                  && stat.loop_more;

    always_comb
    begin
        upc_step = uw.tgt;
        done     = 1'b0;
        unique case (uw.br)
            BR_SEQ:       upc_step = uw.tgt;
            BR_DISPATCH:
            begin
                upc_step = stat.disp_upc;
                done     = stat.disp_done;
            end
            BR_LOOP:      upc_step = stay ? upc_reg : uw.tgt;
            BR_LOOP_OP:   upc_step = stay ? upc_reg : stat.op_upc;
            BR_LOOP_DONE:
            begin
                upc_step = upc_reg;
                done     = !stay;
            end
            BR_DONE:      done = 1'b1;
            default:      done = 1'b1;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = UA_DISPATCH;
        end
        else if (step)
        begin
            upc_next = upc_step;
            if (done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= UA_DISPATCH;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    assign ctl = '{
        emit:  uw.emit,
        ld:    uw.ld,
        step:  step,
        leave: step && !stay,
        disp:  step && uw.br == BR_DISPATCH,
        last:  uw.br == BR_DONE || (uw.br == BR_LOOP_DONE && !stay),
        done:  step && done
    };
    assign busy = busy_reg;

    `CFA_ASSERT_NEXT(a_done_idle, clk, rst_n, step && done, !busy_reg)
    `CFA_ASSERT_NEXT(a_start_dispatch, clk, rst_n, start, busy_reg && upc_reg == UA_DISPATCH)
    `CFA_ASSERT_NEXT(a_stall_holds, clk, rst_n, busy_reg && !step, upc_reg == $past(upc_reg))

endmodule

// ----- rtl/core/cfa_enc_dpath.sv -----
`include "cfa_instruction_encoder_core_defines.svh"

module cfa_enc_dpath #(
    parameter int MAX_CODE_SIZE = cfa_enc_pkg::MAX_CODE_SIZE_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [cfa_enc_pkg::OP_W-1:0]           opcode,
    input  logic [cfa_enc_pkg::CODE_W-1:0]         code_offset,
    input  logic [cfa_enc_pkg::REG_W-1:0]          register_id,
    input  logic signed [cfa_enc_pkg::OFF_W-1:0]   frame_offset,
    input  logic                                   cfg_write_en,
    input  logic [cfa_enc_pkg::CODE_W-1:0]         cfg_write_data,
    input  cfa_enc_pkg::seq_ctl_t                  ctl,
    output cfa_enc_pkg::dp_stat_t                  stat,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [cfa_enc_pkg::BYTE_W-1:0]         out_byte,
    output logic                                   last,
    output logic [cfa_enc_pkg::ERR_W-1:0]          error_code
);
    import cfa_enc_pkg::*;

    localparam logic [CODE_W-1:0] MAX_CS = CODE_W'(MAX_CODE_SIZE);

    // latched item
    logic [OP_W-1:0]   op_reg;
    logic [CODE_W-1:0] offs_reg;
    logic [REG_W-1:0]  rid_reg;
    logic [OFF_W-1:0]  raw_reg;

    // frame state
    logic [CODE_W-1:0] code_size_reg, code_size_next;
    logic [CODE_W-1:0] pos_reg, pos_next;
    logic [1:0]        phase_reg, phase_next;
    logic              failed_reg, failed_next;

    // work registers
    logic [CODE_W-1:0] delta_reg, delta_next;
    logic [OFF_W-1:0]  val_reg, val_next;
    logic [ERR_W-1:0]  err_reg, err_next;

    // output slot
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic [ERR_W-1:0]  out_err_reg, out_err_next;

    logic              offs_bad;
    logic              reg_bad;
    logic              neg;
    logic              aligned;
    logic [ERR_W-1:0]  chk_err;
    upc_t              op_upc;
    logic [5:0]        adv_step;
    logic [OFF_W-1:0]  neg_raw;
    logic              slot_free;
    logic              emitting;
    logic [BYTE_W-1:0] emit_byte;
    logic              disp_done;
    upc_t              disp_upc;
    logic              loop_more;

    assign offs_bad = offs_reg < pos_reg || offs_reg > code_size_reg;
    assign reg_bad  = rid_reg > REG_MAX;
    assign neg      = raw_reg[OFF_W-1];
    assign aligned  = raw_reg[2:0] == 3'd0;
    assign neg_raw  = '0 - raw_reg;
    assign adv_step = (delta_reg > CODE_W'(ADV_MAX)) ? ADV_MAX : delta_reg[5:0];

    always_comb
    begin
        chk_err = ERR_OK;
        if (offs_bad)
            chk_err = ERR_RANGE;
        else if (op_reg == OP_DEF_CFA)
        begin
            if (reg_bad || neg || !aligned)
                chk_err = ERR_BAD_CFA;
        end
        else if (reg_bad)
            chk_err = ERR_BAD_REG;
        else if (op_reg == OP_SAVE && (!neg || !aligned))
            chk_err = ERR_BAD_SAVE;
    end

    always_comb
    begin
        unique case (op_reg)
            OP_DEF_CFA: op_upc = UA_CFA;
            OP_SAVE:    op_upc = UA_SAVE;
            default:    op_upc = UA_REST;
        endcase
    end

    // dispatch decision for the latched item
    always_comb
    begin
        disp_done = 1'b0;
        disp_upc  = op_upc;
        if (op_reg == OP_FINISH)
        begin
            if (failed_reg || phase_reg == 2'd0)
                disp_done = 1'b1;
            else
                disp_upc = UA_PAD;
        end
        else if (failed_reg || chk_err != ERR_OK)
            disp_upc = UA_ERR;
        else if (offs_reg != pos_reg)
            disp_upc = UA_ADV;
    end

    always_comb
    begin
        case (ctl.emit)
            EM_ADV:  loop_more = delta_reg > CODE_W'(ADV_MAX);
            EM_ULEB: loop_more = val_reg[OFF_W-1:7] != '0;
            EM_PAD:  loop_more = phase_reg != 2'd3;
            default: loop_more = 1'b0;
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign emitting  = ctl.step && ctl.emit != EM_NONE;
    assign stat = '{
        slot_free: slot_free,
        loop_more: loop_more,
        disp_done: disp_done,
        disp_upc:  disp_upc,
        op_upc:    op_upc
    };

    always_comb
    begin
        case (ctl.emit)
            EM_ADV:  emit_byte = BYTE_ADV | {2'b00, adv_step};
            EM_CFA:  emit_byte = BYTE_DEFCFA;
            EM_ULEB: emit_byte = (loop_more ? BYTE_CONT : '0) | {1'b0, val_reg[6:0]};
            EM_SAVE: emit_byte = BYTE_SAVE | {3'b000, rid_reg};
            EM_REST: emit_byte = BYTE_REST | {3'b000, rid_reg};
            default: emit_byte = '0;
        endcase
    end

    always_comb
    begin
        code_size_next = code_size_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        failed_next    = failed_reg;
        delta_next     = delta_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (cfg_write_en)
            code_size_next = (cfg_write_data > MAX_CS) ? MAX_CS : cfg_write_data;

        if (ctl.disp && op_reg != OP_FINISH)
        begin
            if (failed_reg)
                err_next = ERR_FAILED;
            else if (chk_err != ERR_OK)
            begin
                err_next    = chk_err;
                failed_next = 1'b1;
            end
            else
            begin
                delta_next = offs_reg - pos_reg;
                pos_next   = offs_reg;
            end
        end

        if (out_ready)
            out_valid_next = 1'b0;

        if (emitting)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = ctl.emit == EM_ERR || ctl.last;
            out_err_next   = (ctl.emit == EM_ERR) ? err_reg : ERR_OK;
            if (ctl.emit != EM_ERR)
                phase_next = 2'(phase_reg + 2'd1);
            if (ctl.emit == EM_ADV)
                delta_next = delta_reg - {5'b00000, adv_step};
            if (ctl.emit == EM_ULEB)
                val_next = val_reg >> 7;
        end

        if (ctl.leave)
        begin
            case (ctl.ld)
                LD_REG:  val_next = {{(OFF_W-REG_W){1'b0}}, rid_reg};
                LD_RAW:  val_next = raw_reg;
                LD_SAVE: val_next = neg_raw >> 3;
                default: ;
            endcase
        end

        // a finished frame starts over
        if (ctl.done && op_reg == OP_FINISH)
        begin
            pos_next    = '0;
            phase_next  = 2'd1;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_size_reg <= MAX_CS;
            pos_reg       <= '0;
            phase_reg     <= 2'd1;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            code_size_reg <= code_size_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= opcode;
            offs_reg <= code_offset;
            rid_reg  <= register_id;
            raw_reg  <= frame_offset;
        end
        delta_reg    <= delta_next;
        val_reg      <= val_next;
        err_reg      <= err_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = out_last_reg;
    assign error_code = out_err_reg;

    `CFA_ASSERT_IMPL(a_err_is_last, clk, rst_n, out_valid_reg && out_err_reg != ERR_OK,
        out_last_reg && out_byte_reg == '0)
    `CFA_ASSERT_IMPL(a_err_frame_failed, clk, rst_n, emitting && ctl.emit == EM_ERR,
        failed_reg)
    `CFA_ASSERT_NEXT(a_finish_resets, clk, rst_n, ctl.done && op_reg == OP_FINISH,
        phase_reg == 2'd1 && pos_reg == '0 && !failed_reg)

endmodule

// ----- rtl/core/cfa_instruction_encoder_core.sv -----
// Call-frame instruction encoder: turns unwind actions into the byte stream of
// a call-frame program, one byte per output transfer.
// Input channel (in_valid/in_ready): one action per transfer. The block takes
// one action at a time; in_ready is high whenever no action is in progress.
// Output channel (out_valid/out_ready): one byte per transfer with last set on
// the final byte of an action and error_code nonzero on an error result.
// A microcode sequencer takes one dispatch step per action and then emits one
// byte per cycle while the output is not stalled; the next input is taken once
// the action is done, and a finish with nothing to pad emits no byte.
// A stalled output holds the byte in its register and freezes the sequencer.
// Configuration: cfg_write_en/cfg_write_data set the code size, saturated to
// MAX_CODE_SIZE; write only while the block is idle.
// Reset: code size returns to MAX_CODE_SIZE, the frame state clears (position
// 0, byte phase 1, not failed) and the output channel empties.
module cfa_instruction_encoder_core #(
    parameter int MAX_CODE_SIZE = cfa_enc_pkg::MAX_CODE_SIZE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cfa_enc_pkg::OP_W-1:0]         opcode,
    input  logic [cfa_enc_pkg::CODE_W-1:0]       code_offset,
    input  logic [cfa_enc_pkg::REG_W-1:0]        register_id,
    input  logic signed [cfa_enc_pkg::OFF_W-1:0] frame_offset,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cfa_enc_pkg::BYTE_W-1:0]       out_byte,
    output logic                                 last,
    output logic [cfa_enc_pkg::ERR_W-1:0]        error_code,
    input  logic                                 cfg_write_en,
    input  logic [cfa_enc_pkg::CODE_W-1:0]       cfg_write_data
);
    import cfa_enc_pkg::*;

    seq_ctl_t ctl;
    dp_stat_t stat;
    logic     busy;
    logic     start;

    assign in_ready = !busy;
    assign start    = in_valid && !busy;

    cfa_enc_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    cfa_enc_dpath #(
        .MAX_CODE_SIZE (MAX_CODE_SIZE)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .opcode         (opcode),
        .code_offset    (code_offset),
        .register_id    (register_id),
        .frame_offset   (frame_offset),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .ctl            (ctl),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last           (last),
        .error_code     (error_code)
    );

endmodule

// ----- tb/sv/tb_cfa_instruction_encoder_core.sv -----
`timescale 1ns / 100ps

module tb_cfa_instruction_encoder_core;
    import cfa_enc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic [ERR_W-1:0]  err;
    } cfi_byte_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [OP_W-1:0]         opcode = OP_DEF_CFA;
    logic [CODE_W-1:0]       code_offset = '0;
    logic [REG_W-1:0]        register_id = '0;
    logic signed [OFF_W-1:0] frame_offset = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [BYTE_W-1:0]       out_byte;
    logic                    last;
    logic [ERR_W-1:0]        error_code;
    logic                    cfg_write_en = 1'b0;
    logic [CODE_W-1:0]       cfg_write_data = '0;

    // encoder state as the testbench sees it
    logic [CODE_W-1:0] code_limit;
    logic [CODE_W-1:0] frame_pos;
    logic [1:0]        frame_phase;
    logic              frame_broken;

    cfi_byte_t pending_bytes[$];
    cfi_byte_t burst_q[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    cfa_instruction_encoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .code_offset    (code_offset),
        .register_id    (register_id),
        .frame_offset   (frame_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last           (last),
        .error_code     (error_code),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #(CLK_HALF) clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void queue_byte(input cfi_byte_t item);
        burst_q.insert(burst_q.size(), item);
    endfunction

    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        queue_byte(cfi_byte_t'{b, 1'b0, ERR_OK});
    endfunction

    function automatic void add_uleb(input logic [31:0] v);
        logic [BYTE_W-1:0] b;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0)
                b[7] = 1'b1;
            add_byte(b);
        end while (v != 0);
    endfunction

    // Compute the bytes one action emits and advance the frame state.
    function automatic void encode_action(input logic [OP_W-1:0] op,
                                          input logic [CODE_W-1:0] pos,
                                          input logic [REG_W-1:0] rid,
                                          input logic [31:0] raw);
        logic [ERR_W-1:0]  fault;
        logic [CODE_W-1:0] gap;
        logic [CODE_W-1:0] chunk;
        logic              neg;
        logic              aligned;
        neg = raw[31];
        aligned = (raw[2:0] == 3'd0);
        fault = ERR_OK;
        burst_q.delete();
        if (op == OP_FINISH)
        begin
            if (!frame_broken)
            begin
                while (frame_phase != 2'd0)
                begin
                    add_byte(8'h00);
                    frame_phase = frame_phase + 2'd1;
                end
            end
            frame_pos = '0;
            frame_phase = 2'd1;
            frame_broken = 1'b0;
        end
        else if (frame_broken)
            queue_byte(cfi_byte_t'{8'h00, 1'b1, ERR_FAILED});
        else
        begin
            if (pos < frame_pos || pos > code_limit)
                fault = ERR_RANGE;
            else if (op == OP_DEF_CFA)
            begin
                if (rid > REG_MAX || neg || !aligned)
                    fault = ERR_BAD_CFA;
            end
            else if (rid > REG_MAX)
                fault = ERR_BAD_REG;
            else if (op == OP_SAVE && (!neg || !aligned))
                fault = ERR_BAD_SAVE;

            if (fault != ERR_OK)
            begin
                frame_broken = 1'b1;
                queue_byte(cfi_byte_t'{8'h00, 1'b1, fault});
            end
            else
            begin
                gap = pos - frame_pos;
                while (gap != 0)
                begin
                    chunk = (gap > CODE_W'(ADV_MAX)) ? CODE_W'(ADV_MAX) : gap;
                    add_byte(BYTE_ADV | BYTE_W'(chunk));
                    gap = gap - chunk;
                end
                frame_pos = pos;
                if (op == OP_DEF_CFA)
                begin
                    add_byte(BYTE_DEFCFA);
                    add_uleb(32'(rid));
                    add_uleb(raw);
                end
                else if (op == OP_SAVE)
                begin
                    add_byte(BYTE_SAVE | BYTE_W'(rid));
                    add_uleb((32'd0 - raw) >> 3);
                end
                else
                    add_byte(BYTE_REST | BYTE_W'(rid));
                frame_phase = frame_phase + 2'(burst_q.size());
            end
        end
        if (burst_q.size() > 0)
            burst_q[burst_q.size() - 1].last = 1'b1;
        foreach (burst_q[i])
            pending_bytes.insert(pending_bytes.size(), burst_q[i]);
    endfunction

    task automatic send_action(input logic [OP_W-1:0] op, input int unsigned pos,
                               input int unsigned rid, input logic [31:0] off);
        int gap;
        gap = 0;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        code_offset <= CODE_W'(pos);
        register_id <= REG_W'(rid);
        frame_offset <= off;
        do
            @(posedge clk);
        while (!in_ready);
        encode_action(op, CODE_W'(pos), REG_W'(rid), off);
    endtask

    // Drop valid and hold until every expected byte has left the block.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_code_size(input int unsigned v);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_write_data <= CODE_W'(v);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        code_limit = CODE_W'(v);
    endtask

    task automatic set_idling(input int sender, input int receiver);
        send_idle_pct = sender;
        stall_pct = receiver;
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        // well-formed frame: short and long advances, longest ULEB operands
        send_action(OP_DEF_CFA, 0, 7, 32'd8);
        send_action(OP_SAVE, 1, 16, -32'sd8);
        send_action(OP_SAVE, 64, 0, 32'h8000_0000);
        send_action(OP_DEF_CFA, 2047, 16, 32'h7fff_fff8);
        send_action(OP_RESTORE, 2047, 16, 32'd0);
        send_action(OP_FINISH, 0, 0, 32'd0);
        // failure latches until the frame is finished
        send_action(OP_RESTORE, 5, 17, 32'd0);
        send_action(OP_SAVE, 5, 1, -32'sd8);
        send_action(OP_FINISH, 0, 0, 32'd0);
        send_action(OP_DEF_CFA, 3, 17, 32'd16);
        send_action(OP_FINISH, 0, 0, 32'd0);
        send_action(OP_DEF_CFA, 3, 6, -32'sd8);
        send_action(OP_FINISH, 0, 0, 32'd0);
        send_action(OP_DEF_CFA, 3, 6, 32'd12);
        send_action(OP_FINISH, 0, 0, 32'd0);
        send_action(OP_SAVE, 3, 3, 32'd16);
        send_action(OP_SAVE, 3, 3, -32'sd12);
        send_action(OP_FINISH, 0, 0, 32'd0);
        send_action(OP_SAVE, 3, 31, -32'sd16);
        send_action(OP_FINISH, 0, 0, 32'd0);
        // offset going backwards
        send_action(OP_RESTORE, 10, 2, 32'd0);
        send_action(OP_RESTORE, 9, 2, 32'd0);
        send_action(OP_FINISH, 0, 0, 32'd0);
        // three single-byte actions land on the boundary: finish emits nothing
        send_action(OP_RESTORE, 0, 0, 32'd0);
        send_action(OP_RESTORE, 0, 1, 32'd0);
        send_action(OP_RESTORE, 0, 2, 32'd0);
        send_action(OP_FINISH, 0, 0, 32'd0);
    endtask

    task automatic test_code_size();
        write_code_size(1);
        send_action(OP_DEF_CFA, 1, 7, 32'd16);
        send_action(OP_RESTORE, 2, 7, 32'd0);
        send_action(OP_FINISH, 0, 0, 32'd0);
        write_code_size(63);
        send_action(OP_SAVE, 63, 5, -32'sd24);
        send_action(OP_FINISH, 0, 0, 32'd0);
        write_code_size(2047);
    endtask

    task automatic random_action(output logic [OP_W-1:0] op, output int unsigned pos,
                                 output int unsigned rid, output logic [31:0] off);
        int unsigned step;
        int unsigned mag;
        op = OP_W'($urandom_range(0, 2));
        if ($urandom_range(99) < 10)
        begin
            pos = $urandom_range(0, 2047);
            rid = $urandom_range(0, 31);
            off = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: step = $urandom_range(0, 8);
                1: step = $urandom_range(9, 70);
                default: step = $urandom_range(0, 2047);
            endcase
            pos = frame_pos + step;
            if (pos > code_limit)
                pos = code_limit;
            rid = $urandom_range(0, 16);
            if (op == OP_SAVE)
            begin
                mag = ($urandom >> $urandom_range(4, 31)) + 1;
                off = 32'd0 - (mag << 3);
            end
            else
                off = ($urandom >> $urandom_range(1, 31)) & 32'h7fff_fff8;
        end
    endtask

    task automatic run_frames(input int n_items, input bit drain_midway);
        logic [OP_W-1:0] op;
        int unsigned     pos;
        int unsigned     rid;
        logic [31:0]     off;
        int              sent;
        int              k;
        sent = 0;
        while (sent < n_items)
        begin
            k = $urandom_range(0, 5);
            repeat (k)
            begin
                random_action(op, pos, rid, off);
                send_action(op, pos, rid, off);
                sent++;
            end
            send_action(OP_FINISH, $urandom_range(0, 2047), $urandom_range(0, 31), $urandom);
            sent++;
            if (drain_midway && sent >= n_items / 2)
            begin
                wait_drained();
                drain_midway = 1'b0;
            end
        end
    endtask

    task automatic test_random();
        set_idling(0, 0);
        write_code_size(2047);
        run_frames(17, 1'b0);
        set_idling(82, 0);
        write_code_size($urandom_range(64, 2047));
        run_frames(17, 1'b1);
        set_idling(0, 82);
        write_code_size(1);
        run_frames(17, 1'b0);
        set_idling(17, 17);
        write_code_size($urandom_range(1, 200));
        run_frames(17, 1'b0);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_bytes
        cfi_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %h last %b err %0d",
                                          out_byte, last, error_code));
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.value)
                    report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.value));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", last, want.last));
                if (error_code !== want.err)
                    report_mismatch($sformatf("error_code %0d, want %0d",
                                              error_code, want.err));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        code_limit = CODE_W'(MAX_CODE_SIZE_DEF);
        frame_pos = '0;
        frame_phase = 2'd1;
        frame_broken = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_code_size();
        test_random();
        wait_drained();
        if (pending_bytes.size() != 0)
            report_mismatch("expected bytes never arrived");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
